@@ src/bccr_pkg.sv @@
// Shared types and constants of the box-circle collision resolver.
package bccr_pkg;

  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 17;
  localparam int unsigned Axes      = 3;

  localparam logic signed [17:0] OneQ16  = 18'sd65536;
  localparam logic signed [17:0] DiagQ16 = 18'sd46341;

  typedef struct packed {
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic signed [31:0] box_z;
    logic signed [31:0] circle_x;
    logic signed [31:0] circle_y;
    logic signed [31:0] circle_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } req_t;

  // Per-item sideband that rides along the root and divide stages.
  typedef struct packed {
    logic                     hit;
    logic [2:0][31:0]         cir;
    logic [2:0][16:0]         d;
    logic signed [17:0]       nx;
    logic signed [17:0]       ny;
    logic [15:0]              m;
  } side_t;

  typedef struct packed {
    logic [31:0] n;
    logic [15:0] root;
    logic [16:0] rem;
  } sq_t;

  typedef struct packed {
    logic [31:0] n;
    logic [15:0] rem;
    logic [16:0] q;
  } dv_t;

  typedef dv_t [2:0] dv3_t;

endpackage

@@ src/bccr_if.sv @@
// Query and result channel interfaces.
interface bccr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_x;
  logic signed [31:0] box_y;
  logic signed [31:0] box_z;
  logic signed [31:0] circle_x;
  logic signed [31:0] circle_y;
  logic signed [31:0] circle_z;
  logic [30:0]        half_x;
  logic [30:0]        half_y;
  logic [30:0]        half_z;
  modport source(output valid, box_x, box_y, box_z, circle_x, circle_y, circle_z,
                 half_x, half_y, half_z, input ready);
  modport sink(input valid, box_x, box_y, box_z, circle_x, circle_y, circle_z,
               half_x, half_y, half_z, output ready);
endinterface

interface bccr_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] escape_x;
  logic signed [31:0] escape_y;
  logic signed [31:0] escape_z;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  modport source(output valid, hit, escape_x, escape_y, escape_z, normal_x, normal_y,
                 input ready);
  modport sink(input valid, hit, escape_x, escape_y, escape_z, normal_x, normal_y,
               output ready);
endinterface

@@ src/box_circle_collision_resolve.sv @@
// Top level of the box-circle collision resolver pipeline.
// Resolves one axis-aligned box against a unit circle per word. The block is
// a 37-stage pipeline that takes a new query word every cycle while the output
// side does not stall. Three stages clamp the offset, square and sum it and pick
// the normal. Sixteen stages take the integer square root of |d|^2, one root bit
// each. Seventeen stages divide the three |d| components by that root, one
// quotient bit each. One stage forms the saturated escape position into the
// output register.
// A stall on the output freezes every stage together, so nothing is lost or
// repeated; the query side is ready whenever the output register is empty or
// being drained. Missed queries report hit low with all other fields zero.
module box_circle_collision_resolve (
  input  logic       clk_i,
  input  logic       rst_ni,
  bccr_in_if.sink    req_i,
  bccr_out_if.source rsp_o
);

  localparam int unsigned SqN = bccr_pkg::SqrtSteps;
  localparam int unsigned DvN = bccr_pkg::DivSteps;

  logic en;
  logic out_valid_q;

  // Advance the whole pipe when the output register can take a word.
  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  bccr_pkg::req_t req;
  assign req = '{box_x: req_i.box_x, box_y: req_i.box_y, box_z: req_i.box_z,
                 circle_x: req_i.circle_x, circle_y: req_i.circle_y,
                 circle_z: req_i.circle_z, half_x: req_i.half_x,
                 half_y: req_i.half_y, half_z: req_i.half_z};

  logic            sv    [SqN+1];
  bccr_pkg::side_t sside [SqN+1];
  bccr_pkg::sq_t   ssq   [SqN+1];

  bccr_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req_i.valid), .req_i(req),
    .valid_o(sv[0]), .side_o(sside[0]), .sq_o(ssq[0])
  );

  // Root bits from most to least significant.
  for (genvar k = 0; k < SqN; k++) begin : g_sqrt
    bccr_sqrt_stage #(.K(SqN - 1 - k)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sv[k]), .side_i(sside[k]), .sq_i(ssq[k]),
      .valid_o(sv[k+1]), .side_o(sside[k+1]), .sq_o(ssq[k+1])
    );
  end

  logic            dvv   [DvN+1];
  bccr_pkg::side_t dside [DvN+1];
  bccr_pkg::dv3_t  ddv   [DvN+1];

  // Set up the rounded numerators |d|*2^16 + m/2 for each axis.
  always_comb begin
    logic [15:0] ad;
    logic [31:0] num;
    dvv[0]     = sv[SqN];
    dside[0]   = sside[SqN];
    dside[0].m = ssq[SqN].root;
    for (int i = 0; i < 3; i++) begin
      ad         = sside[SqN].d[i][16] ? 16'(-sside[SqN].d[i]) : sside[SqN].d[i][15:0];
      num        = {ad, 16'h0000} + 32'(ssq[SqN].root[15:1]);
      ddv[0][i].n   = num;
      ddv[0][i].rem = {1'b0, num[31:17]};
      ddv[0][i].q   = '0;
    end
  end

  for (genvar b = 0; b < DvN; b++) begin : g_div
    bccr_div_stage #(.B(DvN - 1 - b)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dvv[b]), .side_i(dside[b]), .dv_i(ddv[b]),
      .valid_o(dvv[b+1]), .side_o(dside[b+1]), .dv_o(ddv[b+1])
    );
  end

  // Escape = c + d - u, saturated; zero everything on a miss.
  logic [2:0][31:0]   esc_d, esc_q;
  logic               hit_q;
  logic signed [17:0] nx_q, ny_q;

  always_comb begin
    logic signed [33:0] u, sum;
    bccr_pkg::side_t s;
    s = dside[DvN];
    for (int i = 0; i < 3; i++) begin
      if (s.m == '0) begin
        u = '0;
      end else begin
        u = s.d[i][16] ? -$signed({17'd0, ddv[DvN][i].q}) : $signed({17'd0, ddv[DvN][i].q});
      end
      sum = 34'($signed(s.cir[i])) + 34'($signed(s.d[i])) - u;
      if (!s.hit) begin
        esc_d[i] = '0;
      end else if (sum > 34'sd2147483647) begin
        esc_d[i] = 32'h7fff_ffff;
      end else if (sum < -34'sd2147483648) begin
        esc_d[i] = 32'h8000_0000;
      end else begin
        esc_d[i] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dvv[DvN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      esc_q <= esc_d;
      hit_q <= dside[DvN].hit;
      nx_q  <= dside[DvN].hit ? dside[DvN].nx : '0;
      ny_q  <= dside[DvN].hit ? dside[DvN].ny : '0;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.hit      = hit_q;
  assign rsp_o.escape_x = esc_q[0];
  assign rsp_o.escape_y = esc_q[1];
  assign rsp_o.escape_z = esc_q[2];
  assign rsp_o.normal_x = nx_q;
  assign rsp_o.normal_y = ny_q;

endmodule

@@ src/bccr_front.sv @@
// Clamp, hit test and normal choice: three register stages.
module bccr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  bccr_pkg::req_t    req_i,
  output logic              valid_o,
  output bccr_pkg::side_t   side_o,
  output bccr_pkg::sq_t     sq_o
);

  logic [2:0][31:0] box, cir;
  logic [2:0][30:0] half;

  // stage 1 results
  logic [2:0][16:0] d1_d, d1_q;
  logic [2:0]       big_d;
  logic             big1_q;
  logic [2:0][31:0] cir1_q;
  logic [1:0][30:0] apd_d, apd1_q, half1_q;
  logic [1:0]       pneg_d, pneg1_q;
  logic             v1_q;

  // stage 2 results
  logic [33:0]      s2_q;
  logic [61:0]      lhs2_q, rhs2_q;
  logic             big2_q;
  logic [2:0][31:0] cir2_q;
  logic [2:0][16:0] d2_q;
  logic [1:0]       pneg2_q;
  logic             v2_q;

  // stage 3
  logic             v3_q;
  bccr_pkg::side_t  side3_d, side3_q;
  logic [31:0]      n3_q;

  assign box  = {req_i.box_z, req_i.box_y, req_i.box_x};
  assign cir  = {req_i.circle_z, req_i.circle_y, req_i.circle_x};
  assign half = {req_i.half_z, req_i.half_y, req_i.half_x};

  always_comb begin
    logic signed [33:0] diff, h, pd, dd;
    for (int i = 0; i < 3; i++) begin
      diff = 34'($signed(cir[i])) - 34'($signed(box[i]));
      h    = $signed({3'b000, half[i]});
      if (diff > h) begin
        pd = h;
      end else if (diff < -h) begin
        pd = -h;
      end else begin
        pd = diff;
      end
      dd       = pd - diff;
      d1_d[i]  = dd[16:0];
      big_d[i] = (dd > 34'sd65535) || (dd < -34'sd65535);
      if (i < 2) begin
        pneg_d[i] = pd[33];
        apd_d[i]  = pd[33] ? 31'(-pd) : pd[30:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 2: squares and cross products
  logic [61:0] lhs_d, rhs_d;
  logic [33:0] s_d;
  always_comb begin
    logic [30:0] nx, ny, dx, dy;
    logic [16:0] ad;
    nx = apd1_q[0];
    dx = half1_q[0];
    ny = apd1_q[1];
    dy = half1_q[1];
    if (dx == '0) begin
      nx = '0;
      dx = 31'd1;
    end
    if (dy == '0) begin
      ny = '0;
      dy = 31'd1;
    end
    lhs_d = 62'(nx) * 62'(dy);
    rhs_d = 62'(ny) * 62'(dx);
    s_d   = '0;
    for (int i = 0; i < 3; i++) begin
      ad  = d1_q[i][16] ? 17'(-d1_q[i]) : d1_q[i];
      s_d = s_d + 34'(ad) * 34'(ad);
    end
  end

  // stage 3: hit and normal
  always_comb begin
    logic [16:0] ax, ay;
    logic signed [17:0] nx, ny;
    ax = d2_q[0][16] ? 17'(-d2_q[0]) : d2_q[0];
    ay = d2_q[1][16] ? 17'(-d2_q[1]) : d2_q[1];
    nx = '0;
    ny = '0;
    if (lhs2_q > rhs2_q) begin
      nx = pneg2_q[0] ? -bccr_pkg::OneQ16 : bccr_pkg::OneQ16;
    end else if (rhs2_q > lhs2_q) begin
      ny = pneg2_q[1] ? -bccr_pkg::OneQ16 : bccr_pkg::OneQ16;
    end else if (ax > ay) begin
      nx = d2_q[0][16] ? bccr_pkg::OneQ16 : -bccr_pkg::OneQ16;
    end else if (ay > ax) begin
      ny = d2_q[1][16] ? bccr_pkg::OneQ16 : -bccr_pkg::OneQ16;
    end else begin
      nx = bccr_pkg::DiagQ16;
      ny = bccr_pkg::DiagQ16;
    end
    side3_d.hit = !big2_q && (s2_q[33:32] == 2'b00);
    side3_d.cir = cir2_q;
    side3_d.d   = d2_q;
    side3_d.nx  = nx;
    side3_d.ny  = ny;
    side3_d.m   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q    <= d1_d;
      big1_q  <= |big_d;
      cir1_q  <= cir;
      apd1_q  <= apd_d;
      half1_q <= half[1:0];
      pneg1_q <= pneg_d;
      s2_q    <= s_d;
      lhs2_q  <= lhs_d;
      rhs2_q  <= rhs_d;
      big2_q  <= big1_q;
      cir2_q  <= cir1_q;
      d2_q    <= d1_q;
      pneg2_q <= pneg1_q;
      side3_q <= side3_d;
      n3_q    <= s2_q[31:0];
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;
  assign sq_o    = '{n: n3_q, root: '0, rem: '0};

endmodule

@@ src/bccr_sqrt_stage.sv @@
// One bit of the pipelined integer square root.
module bccr_sqrt_stage #(
  parameter int unsigned K = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  bccr_pkg::side_t side_i,
  input  bccr_pkg::sq_t   sq_i,
  output logic            valid_o,
  output bccr_pkg::side_t side_o,
  output bccr_pkg::sq_t   sq_o
);

  logic            valid_q;
  bccr_pkg::side_t side_q;
  bccr_pkg::sq_t   sq_d, sq_q;

  always_comb begin
    logic [18:0] trial, t;
    trial = {sq_i.rem, sq_i.n[2*K+1 -: 2]};
    t     = {1'b0, sq_i.root, 2'b01};
    sq_d.n = sq_i.n;
    if (trial >= t) begin
      sq_d.rem  = 17'(trial - t);
      sq_d.root = {sq_i.root[14:0], 1'b1};
    end else begin
      sq_d.rem  = trial[16:0];
      sq_d.root = {sq_i.root[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      sq_q   <= sq_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign sq_o    = sq_q;

endmodule

@@ src/bccr_div_stage.sv @@
// One quotient bit of the three-lane restoring divider.
module bccr_div_stage #(
  parameter int unsigned B = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  bccr_pkg::side_t side_i,
  input  bccr_pkg::dv3_t  dv_i,
  output logic            valid_o,
  output bccr_pkg::side_t side_o,
  output bccr_pkg::dv3_t  dv_o
);

  logic            valid_q;
  bccr_pkg::side_t side_q;
  bccr_pkg::dv3_t  dv_d, dv_q;

  always_comb begin
    logic [16:0] t;
    for (int i = 0; i < 3; i++) begin
      t          = {dv_i[i].rem, dv_i[i].n[B]};
      dv_d[i].n  = dv_i[i].n;
      if (t >= {1'b0, side_i.m}) begin
        dv_d[i].rem = 16'(t - {1'b0, side_i.m});
        dv_d[i].q   = {dv_i[i].q[15:0], 1'b1};
      end else begin
        dv_d[i].rem = t[15:0];
        dv_d[i].q   = {dv_i[i].q[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      dv_q   <= dv_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign dv_o    = dv_q;

endmodule
